// ----- hdl/gef_pkg.sv -----
package gef_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_TX_BYTE = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_SEND_ACK = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PROTOCOL_TYPE = 1'b0;
    localparam logic CFG_PEER_CALL_ID = 1'b1;

    // Register reset values.
    localparam logic [15:0] PROTOCOL_TYPE_RESET = 16'h880B;
    localparam logic [15:0] PEER_CALL_ID_RESET = 16'h0000;
    localparam logic [31:0] ACK_NONE = 32'hFFFF_FFFF;

    // Header flag words and receive flag masks.
    localparam logic [15:0] FLAGS_DATA = 16'h3001;
    localparam logic [15:0] FLAGS_DATA_ACK = 16'h3081;
    localparam logic [15:0] FLAGS_ACK_ONLY = 16'h2081;
    localparam logic [15:0] FLAG_SEQ_MASK = 16'h1000;
    localparam logic [15:0] FLAG_ACK_MASK = 16'h0080;

    // Command kinds handed from the front to the back.
    localparam logic [1:0] CMD_TX_HEADER = 2'd0;
    localparam logic [1:0] CMD_TX_BYTE = 2'd1;
    localparam logic [1:0] CMD_ACK_ONLY = 2'd2;
    localparam logic [1:0] CMD_RX_BYTE = 2'd3;

    // Byte counter inside one command, up to 17 bytes.
    localparam int CNT_W = 5;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        pend;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] plen;
        logic [7:0]  data;
        logic        last;
    } cmd_t;

endpackage

// ----- hdl/gef_front.sv -----
module gef_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    input  logic [15:0]         payload_length,
    input  logic                queue_full,
    output logic                push,
    output gef_pkg::cmd_t       push_cmd
);

    logic [31:0] sequence_counter_reg, sequence_counter_next;
    logic [31:0] ack_number_reg, ack_number_next;
    logic [31:0] last_sent_ack_reg, last_sent_ack_next;
    logic [15:0] rx_position_reg, rx_position_next;
    logic [15:0] rx_flag_word_reg, rx_flag_word_next;
    logic [15:0] rx_length_reg, rx_length_next;
    logic [31:0] rx_seq_gather_reg, rx_seq_gather_next;

    logic        accept;
    logic        pend;
    logic [15:0] pos;
    logic [4:0]  hdr_end;
    logic [15:0] idx;
    logic [16:0] idx_plus;
    logic        rx_emit;
    logic        rx_last;

    assign in_ready = !queue_full;
    assign accept = in_valid && in_ready;
    assign pend = ack_number_reg != last_sent_ack_reg;

    // Receive header parser for the byte at hand.
    always_comb
    begin
        rx_flag_word_next = rx_flag_word_reg;
        rx_length_next = rx_length_reg;
        rx_seq_gather_next = rx_seq_gather_reg;
        rx_emit = 1'b0;
        rx_last = 1'b0;
        hdr_end = 5'd8;
        idx = 16'd0;
        idx_plus = 17'd0;
        pos = first_byte ? 16'd0 : rx_position_reg;
        rx_position_next = pos;
        if (pos != 16'hFFFF)
        begin
            if (pos <= 16'd1)
            begin
                rx_flag_word_next = {rx_flag_word_reg[7:0], data_byte};
            end
            else if (pos == 16'd4 || pos == 16'd5)
            begin
                rx_length_next = {rx_length_reg[7:0], data_byte};
            end
            if ((rx_flag_word_next & gef_pkg::FLAG_SEQ_MASK) != 16'd0)
            begin
                if (pos >= 16'd8 && pos <= 16'd11)
                begin
                    rx_seq_gather_next = {rx_seq_gather_reg[23:0], data_byte};
                end
                hdr_end = hdr_end + 5'd4;
            end
            if (pos >= 16'd2 && (rx_flag_word_next & gef_pkg::FLAG_ACK_MASK) != 16'd0)
            begin
                hdr_end = hdr_end + 5'd4;
            end
            idx = pos - {11'd0, hdr_end};
            idx_plus = {1'b0, idx} + 17'd1;
            if (pos >= 16'd8 && pos >= {11'd0, hdr_end} && idx < rx_length_next)
            begin
                rx_emit = 1'b1;
                rx_last = idx_plus == {1'b0, rx_length_next};
            end
            rx_position_next = pos + 16'd1;
        end
        if (last_byte)
        begin
            rx_position_next = 16'd0;
        end
    end

    // Classify the request, update the link state and build the command.
    always_comb
    begin
        sequence_counter_next = sequence_counter_reg;
        ack_number_next = ack_number_reg;
        last_sent_ack_next = last_sent_ack_reg;
        push = 1'b0;
        push_cmd.kind = gef_pkg::CMD_TX_BYTE;
        push_cmd.pend = pend;
        push_cmd.seq = sequence_counter_reg;
        push_cmd.ack = ack_number_reg;
        push_cmd.plen = payload_length;
        push_cmd.data = data_byte;
        push_cmd.last = last_byte;
        if (accept)
        begin
            case (opcode)
                gef_pkg::OP_TX_BYTE:
                begin
                    push = 1'b1;
                    if (first_byte)
                    begin
                        push_cmd.kind = gef_pkg::CMD_TX_HEADER;
                        sequence_counter_next = sequence_counter_reg + 32'd1;
                        if (pend)
                        begin
                            last_sent_ack_next = ack_number_reg;
                        end
                    end
                end
                gef_pkg::OP_RX_BYTE:
                begin
                    push = rx_emit;
                    push_cmd.kind = gef_pkg::CMD_RX_BYTE;
                    push_cmd.last = rx_last;
                    if (pos == 16'd11 && (rx_flag_word_next & gef_pkg::FLAG_SEQ_MASK) != 16'd0)
                    begin
                        ack_number_next = rx_seq_gather_next;
                    end
                end
                gef_pkg::OP_SEND_ACK:
                begin
                    push_cmd.kind = gef_pkg::CMD_ACK_ONLY;
                    if (pend)
                    begin
                        push = 1'b1;
                        last_sent_ack_next = ack_number_reg;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Link and parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequence_counter_reg <= 32'd0;
            ack_number_reg <= gef_pkg::ACK_NONE;
            last_sent_ack_reg <= gef_pkg::ACK_NONE;
            rx_position_reg <= 16'd0;
            rx_flag_word_reg <= 16'd0;
            rx_length_reg <= 16'd0;
            rx_seq_gather_reg <= 32'd0;
        end
        else
        begin
            sequence_counter_reg <= sequence_counter_next;
            ack_number_reg <= ack_number_next;
            last_sent_ack_reg <= last_sent_ack_next;
            if (accept && opcode == gef_pkg::OP_RX_BYTE)
            begin
                rx_position_reg <= rx_position_next;
                rx_flag_word_reg <= rx_flag_word_next;
                rx_length_reg <= rx_length_next;
                rx_seq_gather_reg <= rx_seq_gather_next;
            end
        end
    end

endmodule

// ----- hdl/gef_cmd_queue.sv -----
module gef_cmd_queue
#(
    parameter int DEPTH = gef_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gef_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output gef_pkg::cmd_t   head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    gef_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    // Pointer and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/gef_back.sv -----
module gef_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     protocol_type,
    input  logic [15:0]     peer_call_id,
    input  logic            cmd_valid,
    input  gef_pkg::cmd_t   cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_kind,
    output logic            out_last
);

    localparam int CW = gef_pkg::CNT_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;

    logic          load;
    logic [CW-1:0] final_cnt;
    logic [15:0]   flags;
    logic [15:0]   length;
    logic [31:0]   word32;
    logic [7:0]    sel_byte;
    logic          sel_last;
    logic          is_ack;

    assign is_ack = cmd.kind == gef_pkg::CMD_ACK_ONLY;
    assign load = cmd_valid && (!out_valid_reg || out_ready);
    assign pop = load && cnt_reg == final_cnt;

    // Index of the closing byte of the command.
    always_comb
    begin
        case (cmd.kind)
            gef_pkg::CMD_TX_HEADER: final_cnt = cmd.pend ? CW'(16) : CW'(12);
            gef_pkg::CMD_ACK_ONLY:  final_cnt = CW'(11);
            default:                final_cnt = CW'(0);
        endcase
    end

    // Pick the wire byte for the current position.
    always_comb
    begin
        flags = is_ack ? gef_pkg::FLAGS_ACK_ONLY
              : (cmd.pend ? gef_pkg::FLAGS_DATA_ACK : gef_pkg::FLAGS_DATA);
        length = is_ack ? 16'd0 : cmd.plen;
        word32 = is_ack ? cmd.ack : cmd.seq;
        sel_last = is_ack ? (cnt_reg == final_cnt) : (cnt_reg == final_cnt && cmd.last);
        if (!is_ack && cnt_reg == final_cnt)
        begin
            sel_byte = cmd.data;
        end
        else
        begin
            case (cnt_reg)
                CW'(0):  sel_byte = flags[15:8];
                CW'(1):  sel_byte = flags[7:0];
                CW'(2):  sel_byte = protocol_type[15:8];
                CW'(3):  sel_byte = protocol_type[7:0];
                CW'(4):  sel_byte = length[15:8];
                CW'(5):  sel_byte = length[7:0];
                CW'(6):  sel_byte = peer_call_id[15:8];
                CW'(7):  sel_byte = peer_call_id[7:0];
                CW'(8):  sel_byte = word32[31:24];
                CW'(9):  sel_byte = word32[23:16];
                CW'(10): sel_byte = word32[15:8];
                CW'(11): sel_byte = word32[7:0];
                CW'(12): sel_byte = cmd.ack[31:24];
                CW'(13): sel_byte = cmd.ack[23:16];
                CW'(14): sel_byte = cmd.ack[15:8];
                CW'(15): sel_byte = cmd.ack[7:0];
                default: sel_byte = cmd.data;
            endcase
        end
    end

    // Output register and byte counter.
    always_comb
    begin
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next = out_byte_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next = sel_byte;
            out_kind_next = cmd.kind == gef_pkg::CMD_RX_BYTE;
            out_last_next = sel_last;
            cnt_next = (cnt_reg == final_cnt) ? '0 : cnt_reg + CW'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_kind = out_kind_reg;
    assign out_last = out_last_reg;

endmodule

// ----- hdl/gre_enhanced_framer_deframer.sv -----
// Enhanced GRE framer and deframer. Requests enter one per cycle while the command queue
// (QUEUE_DEPTH entries) has room; the front updates the sequence, acknowledgement and
// receive parser state at acceptance and queues at most one command per request. The back
// drives one wire byte per cycle while out_ready allows, through a registered output: a
// packet start emits 13 bytes, or 17 with a pending acknowledgement, an ack-only request 12
// bytes, and any other transmit or received payload byte one. The output byte rate of the
// back therefore sets the sustained rate; a result passes the command queue and then the
// output register. Configuration writes are taken at once and belong only in idle periods.
module gre_enhanced_framer_deframer
#(
    parameter int QUEUE_DEPTH = gef_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [15:0] payload_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_kind,
    output logic        out_last
);

    logic [15:0]   protocol_type_reg;
    logic [15:0]   peer_call_id_reg;
    logic          queue_full;
    logic          push;
    gef_pkg::cmd_t push_cmd;
    logic          pop;
    logic          head_valid;
    gef_pkg::cmd_t head_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_type_reg <= gef_pkg::PROTOCOL_TYPE_RESET;
            peer_call_id_reg <= gef_pkg::PEER_CALL_ID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gef_pkg::CFG_PROTOCOL_TYPE: protocol_type_reg <= cfg_data;
                gef_pkg::CFG_PEER_CALL_ID:  peer_call_id_reg <= cfg_data;
                default:                    protocol_type_reg <= protocol_type_reg;
            endcase
        end
    end

    gef_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .payload_length (payload_length),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    gef_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    gef_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .protocol_type (protocol_type_reg),
        .peer_call_id  (peer_call_id_reg),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_kind      (out_kind),
        .out_last      (out_last)
    );

endmodule
